>>> src/cws_pkg.sv
// Shared types and constants for the congestion window sender.
`timescale 1ns / 1ps

package cws_pkg;

  // Fixed field widths of the channels
  localparam int unsigned OP_W      = 2;
  localparam int unsigned SEQ_IO_W  = 20;
  localparam int unsigned WIN_W     = 16;
  localparam int unsigned CWND_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 20;

  // Event codes
  localparam logic [OP_W-1:0] OP_START   = 2'd0;
  localparam logic [OP_W-1:0] OP_ACK     = 2'd1;
  localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd1;

  // Reset values
  localparam logic [SEQ_IO_W-1:0] TOTAL_RST  = 20'd10000;
  localparam logic [WIN_W-1:0]    THRESH_RST = 16'd64;
  localparam logic [WIN_W-1:0]    THRESH_MIN = 16'd2;
  localparam logic [CWND_W-1:0]   CWND_MAX   = 32'hFFFF_FFFF;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // latch the input beat
    logic div_start;  // launch 1/cwnd division
    logic apply;      // update window state for the event
    logic limit;      // compute end of send run
    logic send;       // load the result register
  } cws_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_div;   // new ack in congestion avoidance
  } cws_sts_t;

endpackage

>>> src/cws_if.sv
// Channel interfaces: event input, result output and configuration write.
`timescale 1ns / 1ps

interface cws_in_if;
  import cws_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [SEQ_IO_W-1:0] ack_number;
  logic [WIN_W-1:0]    peer_window;
  modport source (output valid, op, ack_number, peer_window, input ready);
  modport sink   (input valid, op, ack_number, peer_window, output ready);
endinterface

interface cws_out_if;
  import cws_pkg::*;
  logic                valid;
  logic                ready;
  logic [SEQ_IO_W-1:0] send_first;
  logic [WIN_W-1:0]    send_count;
  logic [CWND_W-1:0]   congestion_window;
  logic                in_slow_start;
  logic                finished;
  modport source (output valid, send_first, send_count, congestion_window, in_slow_start,
                  finished, input ready);
  modport sink   (input valid, send_first, send_count, congestion_window, in_slow_start,
                  finished, output ready);
endinterface

interface cws_cfg_if;
  import cws_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/cws_div.sv
// Restoring divider: 2^(2*FRAC_BITS) / divisor, one quotient bit per cycle.
`timescale 1ns / 1ps

module cws_div
  import cws_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [CWND_W-1:0]     divisor,
  output logic                  done,
  output logic [2*FRAC_BITS:0]  quotient
);

  localparam int unsigned QW    = 2 * FRAC_BITS + 1;
  localparam int unsigned CNT_W = $clog2(QW + 1);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(QW - 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CWND_W:0]   rem_r;
  logic [CWND_W-1:0] div_r;
  logic [QW-1:0]     quo_r;

  logic [CWND_W:0]   shifted;
  logic              fits;

  // Dividend is a single one at its top bit, zeros below
  assign shifted = {rem_r[CWND_W-1:0], (cnt_r == '0)};
  assign fits    = shifted >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        done_r <= 1'b0;
      end else if (busy_r) begin
        cnt_r  <= cnt_r + 1'b1;
        busy_r <= (cnt_r != LAST);
        done_r <= (cnt_r == LAST);
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  // Remainder and quotient shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? (shifted - {1'b0, div_r}) : shifted;
      quo_r <= {quo_r[QW-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> src/cws_dp.sv
// Datapath: config registers, window state, send-run arithmetic, result register.
`timescale 1ns / 1ps

module cws_dp
  import cws_pkg::*;
#(
  parameter int unsigned SEQ_WIDTH = 20,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cws_cmd_t              cmd,
  output cws_sts_t              sts,
  // config write
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DAT_W-1:0]  cfg_data,
  // input beat
  input  logic [OP_W-1:0]       in_op,
  input  logic [SEQ_IO_W-1:0]   in_ack_number,
  input  logic [WIN_W-1:0]      in_peer_window,
  // divider
  output logic [CWND_W-1:0]     div_divisor,
  input  logic [2*FRAC_BITS:0]  div_quotient,
  // result payload
  output logic [SEQ_IO_W-1:0]   out_send_first,
  output logic [WIN_W-1:0]      out_send_count,
  output logic [CWND_W-1:0]     out_congestion_window,
  output logic                  out_in_slow_start,
  output logic                  out_finished
);

  localparam int unsigned QW    = 2 * FRAC_BITS + 1;
  localparam int unsigned SUM_W = ((QW > CWND_W) ? QW : CWND_W) + 1;
  localparam int unsigned CMP_W = ((WIN_W + FRAC_BITS > CWND_W) ?
                                   (WIN_W + FRAC_BITS) : CWND_W) + 1;
  localparam logic [CWND_W-1:0] CWND_ONE = CWND_W'(1) << FRAC_BITS;
  localparam logic [32:0]       SEQ_MAX  = 33'h0_FFFF_FFFF >> (32 - SEQ_WIDTH);

  // Config registers
  logic [SEQ_IO_W-1:0]  total_r;
  logic [WIN_W-1:0]     init_thr_r;

  // Window state
  logic [SEQ_WIDTH-1:0] base_r;
  logic [SEQ_WIDTH-1:0] next_r;
  logic [CWND_W-1:0]    cwnd_r;
  logic [WIN_W-1:0]     ssthr_r;
  logic [WIN_W-1:0]     rwnd_r;
  logic                 slow_r;

  // Latched event and end of send run
  logic [OP_W-1:0]      op_r;
  logic [SEQ_WIDTH-1:0] ack_r;
  logic [WIN_W-1:0]     peer_r;
  logic [SEQ_WIDTH-1:0] end_r;

  // Result payload
  logic [SEQ_IO_W-1:0]  first_r;
  logic [WIN_W-1:0]     count_r;
  logic [CWND_W-1:0]    res_cwnd_r;
  logic                 res_slow_r;
  logic                 res_fin_r;

  logic                 ack_new;
  logic [CWND_W:0]      ss_sum;
  logic [CWND_W-1:0]    cwnd_ss;
  logic                 ss_exit;
  logic [SUM_W-1:0]     ca_sum;
  logic [CWND_W-1:0]    cwnd_ca;
  logic [CWND_W-1:0]    half;
  logic [WIN_W-1:0]     half_clamp;
  logic [CWND_W-1:0]    cwnd_int;
  logic [WIN_W-1:0]     lim;
  logic [SEQ_WIDTH-1:0] tot_cap;
  logic [33:0]          run_end;

  // Event decode
  assign ack_new      = (op_r == OP_ACK) && (ack_r > base_r);
  assign sts.need_div = ack_new && !slow_r;
  assign div_divisor  = cwnd_r;

  // Slow start: add one, leave when threshold reached
  assign ss_sum  = {1'b0, cwnd_r} + {1'b0, CWND_ONE};
  assign cwnd_ss = ss_sum[CWND_W] ? CWND_MAX : ss_sum[CWND_W-1:0];
  assign ss_exit = CMP_W'(cwnd_ss) >= (CMP_W'(ssthr_r) << FRAC_BITS);

  // Avoidance: add the reciprocal, saturating
  assign ca_sum  = SUM_W'(cwnd_r) + SUM_W'(div_quotient);
  assign cwnd_ca = (ca_sum > SUM_W'(CWND_MAX)) ? CWND_MAX : ca_sum[CWND_W-1:0];

  // Timeout threshold: half of integer part, clamped to [2, 65535]
  assign half = cwnd_r >> (FRAC_BITS + 1);
  always_comb begin
    priority if (half < CWND_W'(THRESH_MIN)) begin
      half_clamp = THRESH_MIN;
    end else if (half > CWND_W'({WIN_W{1'b1}})) begin
      half_clamp = {WIN_W{1'b1}};
    end else begin
      half_clamp = half[WIN_W-1:0];
    end
  end

  // Send run end: min(base + min(cwnd int, rwnd), capped total)
  assign cwnd_int = cwnd_r >> FRAC_BITS;
  assign lim      = (cwnd_int > CWND_W'(rwnd_r)) ? rwnd_r : cwnd_int[WIN_W-1:0];
  assign tot_cap  = (33'(total_r) > SEQ_MAX) ? SEQ_MAX[SEQ_WIDTH-1:0]
                                             : SEQ_WIDTH'(32'(total_r));
  assign run_end  = 34'(base_r) + 34'(lim);

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r    <= TOTAL_RST;
      init_thr_r <= THRESH_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_TOTAL) begin
        total_r <= cfg_data;
      end else if (cfg_index == CFG_THRESH) begin
        init_thr_r <= cfg_data[WIN_W-1:0];
      end
    end
  end

  // Window state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      next_r  <= '0;
      cwnd_r  <= CWND_ONE;
      ssthr_r <= THRESH_RST;
      rwnd_r  <= '0;
      slow_r  <= 1'b1;
    end else if (cmd.apply) begin
      unique case (op_r)
        OP_START: begin
          base_r  <= '0;
          next_r  <= '0;
          cwnd_r  <= CWND_ONE;
          ssthr_r <= init_thr_r;
          rwnd_r  <= peer_r;
          slow_r  <= 1'b1;
        end
        OP_ACK: begin
          if (ack_new) begin
            base_r <= ack_r;
            if (next_r < ack_r) begin
              next_r <= ack_r;
            end
            rwnd_r <= peer_r;
            if (slow_r) begin
              cwnd_r <= cwnd_ss;
              slow_r <= !ss_exit;
            end else begin
              cwnd_r <= cwnd_ca;
            end
          end
        end
        OP_TIMEOUT: begin
          ssthr_r <= half_clamp;
          cwnd_r  <= CWND_ONE;
          slow_r  <= 1'b1;
          next_r  <= base_r;
        end
        default: begin
          // unused code: state unchanged
        end
      endcase
    end else if (cmd.send) begin
      if (next_r < end_r) begin
        next_r <= end_r;
      end
    end
  end

  // Event latch and run end
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      ack_r  <= SEQ_WIDTH'(32'(in_ack_number));
      peer_r <= in_peer_window;
    end
    if (cmd.limit) begin
      end_r <= (run_end > 34'(tot_cap)) ? tot_cap : run_end[SEQ_WIDTH-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.send) begin
      first_r    <= SEQ_IO_W'(32'(next_r));
      count_r    <= (next_r < end_r) ? WIN_W'(end_r - next_r) : '0;
      res_cwnd_r <= cwnd_r;
      res_slow_r <= slow_r;
      res_fin_r  <= 32'(base_r) >= 32'(total_r);
    end
  end

  assign out_send_first        = first_r;
  assign out_send_count        = count_r;
  assign out_congestion_window = res_cwnd_r;
  assign out_in_slow_start     = res_slow_r;
  assign out_finished          = res_fin_r;

endmodule

>>> src/cws_ctrl.sv
// Controller: sequences one event through evaluate, divide, update, limit, send.
`timescale 1ns / 1ps

module cws_ctrl
  import cws_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  cws_sts_t sts,
  input  logic     div_done,
  output cws_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_LIMIT,
    S_SEND
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Commands decoded from state
  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE:  cmd.load      = in_valid;
      S_EVAL: begin
        cmd.div_start = sts.need_div;
        cmd.apply     = !sts.need_div;
      end
      S_DIV:   cmd.apply     = div_done;
      S_LIMIT: cmd.limit     = 1'b1;
      S_SEND:  cmd.send      = slot_free;
      default: cmd = '0;
    endcase
  end

  // State and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // result valid: set when a beat is loaded, cleared when it is taken
      if (state_r == S_SEND && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          state_r <= sts.need_div ? S_DIV : S_LIMIT;
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_LIMIT;
          end
        end
        S_LIMIT: begin
          state_r <= S_SEND;
        end
        S_SEND: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/congestion_window_sender.sv
// Top level: sender window with slow start and congestion avoidance.
//
//  channel | modport | beat carries                                   | accepted when
//  in_bus  | sink    | op, ack_number, peer_window                    | valid && ready
//  out_bus | source  | send_first, send_count, congestion_window,     | valid && ready
//          |         | in_slow_start, finished                        |
//  cfg_bus | sink    | index, data                                    | valid && ready
//
// An event runs from accept through evaluate, limit and send steps to result valid; a
// new ack in congestion avoidance adds a divide step for the bit-serial 1/cwnd divider.
// One event is in flight at a time; the next is accepted on the cycle after its result
// is loaded into the output register.
// A stalled result stays in the output register while the next event runs; the
// controller waits in its send step only if it is still full. Sync reset, active low.
`timescale 1ns / 1ps

module congestion_window_sender
  import cws_pkg::*;
#(
  parameter int unsigned SEQ_WIDTH = 20,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  cws_in_if.sink    in_bus,
  cws_out_if.source out_bus,
  cws_cfg_if.sink   cfg_bus
);

  cws_cmd_t                cmd;
  cws_sts_t                sts;
  logic                    div_done;
  logic [CWND_W-1:0]       div_divisor;
  logic [2*FRAC_BITS:0]    div_quotient;

  // config is always ready
  assign cfg_bus.ready = 1'b1;

  // Sequencer
  cws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .sts       (sts),
    .div_done  (div_done),
    .cmd       (cmd)
  );

  // Window state and arithmetic
  cws_dp #(
    .SEQ_WIDTH (SEQ_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_we                (cfg_bus.valid),
    .cfg_index             (cfg_bus.index),
    .cfg_data              (cfg_bus.data),
    .in_op                 (in_bus.op),
    .in_ack_number         (in_bus.ack_number),
    .in_peer_window        (in_bus.peer_window),
    .div_divisor           (div_divisor),
    .div_quotient          (div_quotient),
    .out_send_first        (out_bus.send_first),
    .out_send_count        (out_bus.send_count),
    .out_congestion_window (out_bus.congestion_window),
    .out_in_slow_start     (out_bus.in_slow_start),
    .out_finished          (out_bus.finished)
  );

  // Reciprocal for avoidance growth
  cws_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

endmodule

>>> src/cws_chk.sv
// Port-level checks for the congestion window sender, bound to the top level.
`timescale 1ns / 1ps

module cws_chk
  import cws_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SEQ_IO_W-1:0] send_first,
  input logic [WIN_W-1:0]    send_count,
  input logic [CWND_W-1:0]   congestion_window,
  input logic                finished
);

  localparam logic [CWND_W-1:0] CWND_ONE = CWND_W'(1) << FRAC_BITS;

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(send_first) && $stable(send_count))
    else $error("result beat changed while stalled");

  // One event in flight: no accept on the cycle after an accept
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second event accepted while one is in progress");

  // Nothing left to send once the base reached the total
  a_no_send_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && finished |-> send_count == '0)
    else $error("packets scheduled after transfer finished");

  // cwnd never drops below one packet
  a_cwnd_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> congestion_window >= CWND_ONE)
    else $error("congestion window below one");

endmodule

bind congestion_window_sender cws_chk #(
  .FRAC_BITS (FRAC_BITS)
) u_cws_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_bus.valid),
  .in_ready          (in_bus.ready),
  .out_valid         (out_bus.valid),
  .out_ready         (out_bus.ready),
  .send_first        (out_bus.send_first),
  .send_count        (out_bus.send_count),
  .congestion_window (out_bus.congestion_window),
  .finished          (out_bus.finished)
);
